[hw/rtl/rvof_pkg.sv]
// ----------------------------------------------------------------------------
// rvof_pkg
// Shared types and constants for the rectangle vertex order finder.
// ----------------------------------------------------------------------------
package rvof_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned DiffW   = 17;
  localparam int unsigned SqW     = 33;   // |u|^2 up to 2*(2^16-1)^2
  localparam int unsigned DotW    = 33;   // |dot| up to 2*(2^16-1)^2
  localparam int unsigned ThrW    = 16;
  localparam int unsigned NumPerm = 24;
  localparam int unsigned PermW   = 5;
  localparam logic [ThrW-1:0] ThrReset = 16'd6554;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic [1:0]               idx_t;

  typedef struct packed {
    idx_t p0;
    idx_t p1;
    idx_t p2;
    idx_t p3;
  } perm_t;

  // Lexicographic permutation table of four indices.
  function automatic perm_t perm_of(input logic [PermW-1:0] k);
    perm_t p;
    logic [1:0] a, b, c;
    logic [1:0] rest [3];
    logic [2:0] r6;
    p = '0;
    a = k[4:3] == 2'd3 ? 2'd3 : (k >= 5'd18 ? 2'd3 : (k >= 5'd12 ? 2'd2 :
        (k >= 5'd6 ? 2'd1 : 2'd0)));
    r6 = 3'(k - 5'(a) * 5'd6);
    case (a)
      2'd0: begin rest[0] = 2'd1; rest[1] = 2'd2; rest[2] = 2'd3; end
      2'd1: begin rest[0] = 2'd0; rest[1] = 2'd2; rest[2] = 2'd3; end
      2'd2: begin rest[0] = 2'd0; rest[1] = 2'd1; rest[2] = 2'd3; end
      default: begin rest[0] = 2'd0; rest[1] = 2'd1; rest[2] = 2'd2; end
    endcase
    b = rest[r6[2:1]];
    case (r6[2:1])
      2'd0: c = r6[0] ? rest[2] : rest[1];
      2'd1: c = r6[0] ? rest[2] : rest[0];
      default: c = r6[0] ? rest[1] : rest[0];
    endcase
    p.p0 = a;
    p.p1 = b;
    p.p2 = c;
    p.p3 = 2'(4'd6 - 4'(a) - 4'(b) - 4'(c));
    return p;
  endfunction

endpackage

[hw/rtl/rectangle_vertex_order_finder_core.sv]
// ----------------------------------------------------------------------------
// rectangle_vertex_order_finder_core
// A new input is accepted only in S_IDLE, after the previous result is taken.
// The lanes issue orderings in groups, one group a cycle; the 5-stage corner
// pipeline sets the drain. rst_n (sync, active low) clears control and loads
// cos_threshold 6554.
// ----------------------------------------------------------------------------
// Four point coordinates are latched; LANES lanes each test one ordering per
// cycle through a pipelined corner checker. The merger keeps the first
// passing ordering in lexicographic order.
module rectangle_vertex_order_finder_core #(
  parameter int unsigned LANES = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y (16 bits each, low bits first)
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // order_first, order_second, order_third, order_fourth (2 bits each)
  output logic [7:0]   out_tdata,
  // found
  output logic         out_tuser
);
  import rvof_pkg::*;

  localparam int unsigned Groups = (NumPerm + LANES - 1) / LANES;
  localparam int unsigned GW     = $clog2(Groups + 1);
  localparam int unsigned Lat    = 5;   // corner pipeline depth

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [15:0]     thr_r;
  coord_t          px_r [4];
  coord_t          py_r [4];
  logic [GW-1:0]   iss_r;                 // groups issued
  logic [GW-1:0]   ret_r;                 // groups retired
  logic [Lat-1:0]  vpipe_r;
  logic [GW-1:0]   gpipe_r [Lat];
  logic            found_r;
  perm_t           best_r;
  logic            pass [LANES];
  perm_t           lperm [LANES];

  // latch the cos threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrReset;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = found_r;
  assign out_tdata  = {best_r.p3, best_r.p2, best_r.p1, best_r.p0};

  // hold the points for the whole search
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      for (int i = 0; i < 4; i++) begin
        px_r[i] <= in_tdata[32*i +: 16];
        py_r[i] <= in_tdata[32*i+16 +: 16];
      end
    end
  end

  // lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [PermW+GW-1:0] k;
    assign k = (PermW+GW)'(iss_r) * (PermW+GW)'(LANES) + (PermW+GW)'(l);
    assign lperm[l] = perm_of(PermW'(k >= (PermW+GW)'(NumPerm) ? '0 : k));
    rvof_lane u_lane (.clk, .px(px_r), .py(py_r), .perm(lperm[l]), .thr(thr_r),
                      .pass(pass[l]));
  end

  // orderings at the pipeline exit, recomputed from the retiring group
  perm_t xperm [LANES];
  logic  xval  [LANES];
  for (genvar l = 0; l < LANES; l++) begin : g_exit
    logic [PermW+GW-1:0] k;
    assign k = (PermW+GW)'(gpipe_r[Lat-1]) * (PermW+GW)'(LANES) + (PermW+GW)'(l);
    assign xval[l]  = k < (PermW+GW)'(NumPerm);
    assign xperm[l] = perm_of(PermW'(xval[l] ? k : '0));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_RUN;
      S_RUN:  if (vpipe_r[Lat-1] && ret_r == GW'(Groups - 1)) state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= '0;
      ret_r   <= '0;
      vpipe_r <= '0;
      found_r <= 1'b0;
      best_r  <= '0;
    end else begin
      state_r <= state_nxt;
      // shift the issue valid and group pipes
      vpipe_r <= {vpipe_r[Lat-2:0], (state_r == S_RUN) && (iss_r < GW'(Groups))};
      gpipe_r[0] <= iss_r;
      for (int s = 1; s < Lat; s++) gpipe_r[s] <= gpipe_r[s-1];
      if (state_r == S_IDLE) begin
        iss_r   <= '0;
        ret_r   <= '0;
        found_r <= 1'b0;
        best_r  <= '{p0: 2'd0, p1: 2'd1, p2: 2'd2, p3: 2'd3};
      end else if (state_r == S_RUN) begin
        if (iss_r < GW'(Groups)) iss_r <= iss_r + 1'b1;
        if (vpipe_r[Lat-1]) begin
          ret_r <= ret_r + 1'b1;
          // merge: first passing lane in lane order
          if (!found_r) begin
            for (int l = LANES - 1; l >= 0; l--) begin
              if (xval[l] && pass[l]) begin
                found_r <= 1'b1;
                best_r  <= xperm[l];
              end
            end
          end
        end
      end
    end
  end

  // the exit pipe lags issue by exactly the corner latency
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    vpipe_r[Lat-1] |-> (ret_r == gpipe_r[Lat-1]))
    else $error("retire order broken");
  a_nofound_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 8'he4))
    else $error("identity not held");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
endmodule

[hw/rtl/rvof_corner.sv]
// ----------------------------------------------------------------------------
// rvof_corner
// Pipelined near-right-angle test of one corner (five stages).
// ----------------------------------------------------------------------------
module rvof_corner (
  input  logic                   clk,
  input  rvof_pkg::diff_t        ux,
  input  rvof_pkg::diff_t        uy,
  input  rvof_pkg::diff_t        vx,
  input  rvof_pkg::diff_t        vy,
  input  logic [15:0]            thr,
  output logic                   ok
);
  import rvof_pkg::*;

  // stage 1: products
  logic signed [33:0] uxx_r, uyy_r, vxx_r, vyy_r, dx_r, dy_r;
  logic [ThrW-1:0]    t1_r;
  // stage 2: sums
  logic [SqW-1:0]     lu_r, lv_r;
  logic [DotW-1:0]    ad_r;
  logic [31:0]        tt_r;
  // stage 3: lu*lv and ad*ad
  logic [65:0]        luv_r, ad2_r;
  logic [31:0]        tt3_r;
  logic               z3_r;
  // stage 4: lu*lv*thr^2 in two halves
  logic [65:0]        rh_r;
  logic [63:0]        rl_r;
  logic [65:0]        ad4_r;
  logic               z4_r;
  // stage 5: compare
  logic [66:0]        rhs;

  always_ff @(posedge clk) begin
    uxx_r <= ux * ux;
    uyy_r <= uy * uy;
    vxx_r <= vx * vx;
    vyy_r <= vy * vy;
    dx_r  <= ux * vx;
    dy_r  <= uy * vy;
    t1_r  <= thr;
  end

  logic signed [35:0] dot;
  assign dot = 36'(dx_r) + 36'(dy_r);

  always_ff @(posedge clk) begin
    lu_r <= SqW'(uxx_r) + SqW'(uyy_r);
    lv_r <= SqW'(vxx_r) + SqW'(vyy_r);
    ad_r <= DotW'(dot < 0 ? -dot : dot);
    tt_r <= 32'(t1_r) * 32'(t1_r);
  end

  always_ff @(posedge clk) begin
    luv_r <= 66'(lu_r) * 66'(lv_r);
    ad2_r <= 66'(ad_r) * 66'(ad_r);
    tt3_r <= tt_r;
    z3_r  <= (lu_r == '0) || (lv_r == '0);
  end

  always_ff @(posedge clk) begin
    rh_r  <= 66'(luv_r[65:32]) * 66'(tt3_r);
    rl_r  <= 64'(luv_r[31:0]) * 64'(tt3_r);
    ad4_r <= ad2_r;
    z4_r  <= z3_r;
  end

  // dot^2 * 2^32 has zero low bits, so compare against the product shifted
  // down by 32 with the fraction dropped
  assign rhs = 67'(rh_r) + 67'(rl_r[63:32]);

  always_ff @(posedge clk) begin
    ok <= z4_r || (67'(ad4_r) <= rhs);
  end
endmodule

[hw/rtl/rvof_lane.sv]
// ----------------------------------------------------------------------------
// rvof_lane
// One lane: both corner tests for one ordering.
// ----------------------------------------------------------------------------
module rvof_lane (
  input  logic                clk,
  input  rvof_pkg::coord_t    px [4],
  input  rvof_pkg::coord_t    py [4],
  input  rvof_pkg::perm_t     perm,
  input  logic [15:0]         thr,
  output logic                pass
);
  import rvof_pkg::*;

  diff_t ax, ay, bx, by, cx, cy, dx, dy;
  logic  ok1, ok2;

  assign ax = DiffW'(px[perm.p1]) - DiffW'(px[perm.p0]);
  assign ay = DiffW'(py[perm.p1]) - DiffW'(py[perm.p0]);
  assign bx = DiffW'(px[perm.p2]) - DiffW'(px[perm.p1]);
  assign by = DiffW'(py[perm.p2]) - DiffW'(py[perm.p1]);
  assign cx = DiffW'(px[perm.p3]) - DiffW'(px[perm.p2]);
  assign cy = DiffW'(py[perm.p3]) - DiffW'(py[perm.p2]);
  assign dx = DiffW'(px[perm.p0]) - DiffW'(px[perm.p3]);
  assign dy = DiffW'(py[perm.p0]) - DiffW'(py[perm.p3]);

  rvof_corner u_c1 (.clk, .ux(ax), .uy(ay), .vx(bx), .vy(by), .thr, .ok(ok1));
  rvof_corner u_c2 (.clk, .ux(cx), .uy(cy), .vx(dx), .vy(dy), .thr, .ok(ok2));

  assign pass = ok1 && ok2;
endmodule
